// ===== sv/lcdn_pkg.sv =====
package lcdn_pkg;

  // Display command and character codes
  localparam logic [7:0] ADDR_CMD     = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_HEX     = 8'h37;  // 'A' - 10

  localparam logic [1:0] LINE_FIRST = 2'd1;

  // Binary-to-BCD shift iterations per pipeline stage
  localparam int DABBLE_STEP = 4;

  typedef struct packed {
    logic       hex;   // unsigned hex display
    logic       neg;   // leading minus pending
    logic [7:0] addr;  // address-set command byte
  } ctl_t;

  // Upper bound on decimal digits of an nb-bit magnitude (1233/4096 ~ log10 2)
  function automatic int dec_digits(input int nb);
    return ((nb * 1233) >> 12) + 1;
  endfunction

endpackage

// ===== sv/lcdn_if.sv =====
interface lcdn_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  line;
  logic [5:0]  column;
  logic [15:0] value;

  modport source (output valid, cmd, line, column, value, input ready);
  modport sink   (input valid, cmd, line, column, value, output ready);
endinterface

interface lcdn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lcd_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, lcd_byte, is_data, last, input ready);
  modport sink   (input valid, lcd_byte, is_data, last, output ready);
endinterface

// ===== sv/lcdn_prep.sv =====
module lcdn_prep #(
  parameter int NB = 16,
  parameter int BW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcdn_in_if.sink           in_i,
  output logic              valid_o,
  input  logic              ready_i,
  output lcdn_pkg::ctl_t    ctl_o,
  output logic [BW-1:0]     bin_o
);

  logic              valid_q;
  lcdn_pkg::ctl_t    ctl_q, ctl_d;
  logic [BW-1:0]     bin_q, bin_d;
  logic [NB-1:0]     v;
  logic [7:0]        addr;

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    v    = NB'(in_i.value);
    addr = {2'b00, in_i.column} - 8'd1
         + ((in_i.line == lcdn_pkg::LINE_FIRST) ? 8'd0 : lcdn_pkg::LINE2_OFFSET);
    ctl_d.hex  = in_i.cmd;
    ctl_d.neg  = !in_i.cmd && v[NB-1];
    ctl_d.addr = lcdn_pkg::ADDR_CMD | addr;
    bin_d      = ctl_d.neg ? BW'(NB'(~v + 1'b1)) : BW'(v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ctl_q <= ctl_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign bin_o   = bin_q;

endmodule

// ===== sv/lcdn_dabble.sv =====
module lcdn_dabble #(
  parameter int DW = 20,
  parameter int BW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  lcdn_pkg::ctl_t ctl_i,
  input  logic [DW-1:0]  dig_i,
  input  logic [BW-1:0]  bin_i,
  output logic           valid_o,
  input  logic           ready_i,
  output lcdn_pkg::ctl_t ctl_o,
  output logic [DW-1:0]  dig_o,
  output logic [BW-1:0]  bin_o
);

  localparam int ND = DW / 4;

  logic              valid_q;
  lcdn_pkg::ctl_t    ctl_q;
  logic [DW+BW-1:0]  acc_d, acc_q;

  assign ready_o = !valid_q || ready_i;

  // Shift-add-3; in hex mode the correction is off and the bits pass as nibbles
  always_comb begin
    acc_d = {dig_i, bin_i};
    for (int it = 0; it < lcdn_pkg::DABBLE_STEP; it++) begin
      for (int d = 0; d < ND; d++) begin
        if (!ctl_i.hex && acc_d[BW+4*d +: 4] >= 4'd5) begin
          acc_d[BW+4*d +: 4] = acc_d[BW+4*d +: 4] + 4'd3;
        end
      end
      acc_d = {acc_d[DW+BW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q <= ctl_i;
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dig_o   = acc_q[DW+BW-1:BW];
  assign bin_o   = acc_q[BW-1:0];

endmodule

// ===== sv/lcdn_norm.sv =====
module lcdn_norm #(
  parameter int DW = 20,
  parameter int LW = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  lcdn_pkg::ctl_t ctl_i,
  input  logic [DW-1:0]  dig_i,
  output logic           valid_o,
  input  logic           ready_i,
  output lcdn_pkg::ctl_t ctl_o,
  output logic [DW-1:0]  dig_o,
  output logic [LW-1:0]  left_o
);

  localparam int ND = DW / 4;
  localparam int IW = $clog2(ND);

  logic              valid_q;
  lcdn_pkg::ctl_t    ctl_q;
  logic [DW-1:0]     dig_q, dig_d;
  logic [LW-1:0]     left_q, left_d;
  logic [IW-1:0]     top;
  logic [IW-1:0]     sh;

  assign ready_o = !valid_q || ready_i;

  // Find the leading nonzero digit; zero keeps one digit
  always_comb begin
    top = '0;
    for (int i = 0; i < ND; i++) begin
      if (dig_i[4*i +: 4] != 4'd0) begin
        top = IW'(i);
      end
    end
    sh     = IW'(ND - 1) - top;
    dig_d  = dig_i << {sh, 2'b00};
    left_d = LW'(top) + LW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_q  <= ctl_i;
      dig_q  <= dig_d;
      left_q <= left_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dig_o   = dig_q;
  assign left_o  = left_q;

endmodule

// ===== sv/lcdn_emit.sv =====
module lcdn_emit #(
  parameter int DW = 20,
  parameter int LW = 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  lcdn_pkg::ctl_t ctl_i,
  input  logic [DW-1:0]  dig_i,
  input  logic [LW-1:0]  left_i,
  lcdn_out_if.source     out_o
);

  logic          valid_q;
  logic          hdr_q;
  logic          neg_q;
  logic [LW-1:0] left_q;
  logic [7:0]    addr_q;
  logic [DW-1:0] dig_q;
  logic [3:0]    nib;
  logic          last_w;
  logic          beat;

  assign nib    = dig_q[DW-1 -: 4];
  assign last_w = !hdr_q && !neg_q && (left_q == LW'(1));
  assign beat   = valid_q && out_o.ready;

  // Takes the next number while the final beat of this one goes out
  assign ready_o = !valid_q || (out_o.ready && last_w);

  always_comb begin
    out_o.valid   = valid_q;
    out_o.last    = last_w;
    out_o.is_data = !hdr_q;
    if (hdr_q) begin
      out_o.lcd_byte = addr_q;
    end else if (neg_q) begin
      out_o.lcd_byte = lcdn_pkg::CHAR_MINUS;
    end else if (nib >= 4'd10) begin
      out_o.lcd_byte = {4'd0, nib} + lcdn_pkg::CHAR_HEX;
    end else begin
      out_o.lcd_byte = {4'd0, nib} + lcdn_pkg::CHAR_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hdr_q   <= 1'b0;
      neg_q   <= 1'b0;
      left_q  <= '0;
    end else if (ready_o) begin
      valid_q <= valid_i;
      if (valid_i) begin
        hdr_q  <= 1'b1;
        neg_q  <= ctl_i.neg;
        left_q <= left_i;
      end
    end else if (beat) begin
      if (hdr_q) begin
        hdr_q <= 1'b0;
      end else if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        left_q <= left_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      addr_q <= ctl_i.addr;
      dig_q  <= dig_i;
    end else if (beat && !hdr_q && !neg_q) begin
      dig_q <= {dig_q[DW-5:0], 4'd0};
    end
  end

`ifndef NO_ASSERTIONS
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> left_q != '0)
    else $error("emitter holds a number with no digits left");

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> left_q <= LW'(DW / 4))
    else $error("digit count exceeds digit register");

  a_hdr_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && hdr_q) |=> (valid_q && !hdr_q))
    else $error("address beat did not advance to characters");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !last_w) |=> valid_q)
    else $error("number dropped before its final beat");
`endif

endmodule

// ===== sv/lcd_number_to_char_sequence_unit.sv =====
// Number to character-display byte sequence.
// Input channel in_i (valid/ready): cmd (0 signed decimal, 1 unsigned hex),
// line, column and value. A beat is taken when valid and ready are high.
// Output channel out_o (valid/ready): one beat per display byte. First the
// address-set command (is_data = 0), then an optional '-', then the digits
// most significant first with no leading zeros; last marks the final byte.
// A number yields 2 to 2 + ND beats (7 at VALUE_BITS = 16).
// From an input beat to its address beat a number passes the prep register,
// NS = ceil(VALUE_BITS / 4) shift-add-3 stages, the normalizer and emitter.
// Throughput: one output byte per cycle while the receiver is ready; the
// serializer is the limit. The pipeline before it takes a new number each
// cycle until its stages are full.
// The serializer loads the next number in the cycle its last byte is taken.
// When the receiver stalls, the current byte holds and the stages fill and
// then hold; nothing is lost or repeated.
// Reset clears all valid bits; no beat is presented until new input arrives.
module lcd_number_to_char_sequence_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lcdn_in_if.sink     in_i,
  lcdn_out_if.source  out_o
);

  localparam int NB = VALUE_BITS;
  localparam int ND = lcdn_pkg::dec_digits(NB);
  localparam int DW = ND * 4;
  localparam int NS = (NB + lcdn_pkg::DABBLE_STEP - 1) / lcdn_pkg::DABBLE_STEP;
  localparam int BW = NS * lcdn_pkg::DABBLE_STEP;
  localparam int LW = $clog2(ND + 1);

  // Stage bus: index 0 is the prep register, NS the last dabble stage
  logic              st_valid [NS+1];
  logic              st_ready [NS+1];
  lcdn_pkg::ctl_t    st_ctl   [NS+1];
  logic [DW-1:0]     st_dig   [NS+1];
  logic [BW-1:0]     st_bin   [NS+1];

  logic              nm_valid;
  logic              nm_ready;
  lcdn_pkg::ctl_t    nm_ctl;
  logic [DW-1:0]     nm_dig;
  logic [LW-1:0]     nm_left;

  // Sign handling, magnitude and address command
  lcdn_prep #(.NB(NB), .BW(BW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (st_valid[0]),
    .ready_i (st_ready[0]),
    .ctl_o   (st_ctl[0]),
    .bin_o   (st_bin[0])
  );

  assign st_dig[0] = '0;

  // Binary to BCD (or straight nibbles for hex), four bits per stage
  for (genvar s = 0; s < NS; s++) begin : g_dabble
    lcdn_dabble #(.DW(DW), .BW(BW)) u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[s]),
      .ready_o (st_ready[s]),
      .ctl_i   (st_ctl[s]),
      .dig_i   (st_dig[s]),
      .bin_i   (st_bin[s]),
      .valid_o (st_valid[s+1]),
      .ready_i (st_ready[s+1]),
      .ctl_o   (st_ctl[s+1]),
      .dig_o   (st_dig[s+1]),
      .bin_o   (st_bin[s+1])
    );
  end

  // Left-align the digits and count them
  lcdn_norm #(.DW(DW), .LW(LW)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid[NS]),
    .ready_o (st_ready[NS]),
    .ctl_i   (st_ctl[NS]),
    .dig_i   (st_dig[NS]),
    .valid_o (nm_valid),
    .ready_i (nm_ready),
    .ctl_o   (nm_ctl),
    .dig_o   (nm_dig),
    .left_o  (nm_left)
  );

  // Byte serializer and output register
  lcdn_emit #(.DW(DW), .LW(LW)) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nm_valid),
    .ready_o (nm_ready),
    .ctl_i   (nm_ctl),
    .dig_i   (nm_dig),
    .left_i  (nm_left),
    .out_o   (out_o)
  );

endmodule

// ===== verif/lcd_number_to_char_sequence_unit_tb.sv =====
`timescale 1ns / 100ps

// Testbench for lcd_number_to_char_sequence_unit.
// A software predictor works out the address command and the character bytes
// for each accepted number and queues them; a checker pops and compares on
// every output beat. The sender and receiver idle at random, and one phase
// stalls the receiver long enough to back the whole pipeline up.
module lcd_number_to_char_sequence_unit_tb;

  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  // no beat on either channel for this long means the block has hung
  localparam int WATCHDOG_LIMIT = 5000;
  // long receiver hold for the pressure phase; far above pipeline depth
  localparam int LONG_HOLD      = 200;
  // tail after the last expected byte; well above the pipeline latency
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } lcd_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  lcdn_in_if  in_if ();
  lcdn_out_if out_if ();

  lcd_number_to_char_sequence_unit #(
    .VALUE_BITS(16)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // display bytes still owed by the block, oldest first
  lcd_beat_t pending_bytes[$];

  int mismatch_cnt = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor: address command, optional minus, digits MSD first.
  function automatic void predict_display_bytes(input logic mode, input logic [1:0] ln,
                                                input logic [5:0] col, input logic [15:0] v);
    lcd_beat_t   seq[$];
    logic [3:0]  digs[$];
    logic [7:0]  addr;
    logic [16:0] mag;
    logic [7:0]  ch;
    int          radix;
    // column - 1 wraps within 8 bits; any line but the first is the second
    addr = {2'b00, col} + 8'hFF
         + ((ln == lcdn_pkg::LINE_FIRST) ? 8'h00 : lcdn_pkg::LINE2_OFFSET);
    seq.push_back('{lcd_byte: lcdn_pkg::ADDR_CMD | addr, is_data: 1'b0, last: 1'b0});
    mag   = {1'b0, v};
    radix = (mode == MODE_HEX) ? 16 : 10;
    if (mode == MODE_DEC && v[15]) begin
      seq.push_back('{lcd_byte: lcdn_pkg::CHAR_MINUS, is_data: 1'b1, last: 1'b0});
      mag = 17'h10000 - {1'b0, v};  // -32768 gives 32768, no overflow
    end
    // zero still yields one digit
    do begin
      digs.push_front(4'(mag % radix));
      mag = 17'(mag / radix);
    end while (mag != 0);
    foreach (digs[i]) begin
      ch = (digs[i] >= 4'd10) ? lcdn_pkg::CHAR_HEX + 8'(digs[i])
                              : lcdn_pkg::CHAR_ZERO + 8'(digs[i]);
      seq.push_back('{lcd_byte: ch, is_data: 1'b1, last: 1'b0});
    end
    seq[seq.size()-1].last = 1'b1;
    foreach (seq[i]) pending_bytes.push_back(seq[i]);
  endfunction

  // Offer one number, with random gaps before it; returns after its beat.
  // valid stays high into the next call so back-to-back beats are possible.
  task automatic send_number(input logic mode, input logic [1:0] ln,
                             input logic [5:0] col, input logic [15:0] v);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.cmd    <= mode;
    in_if.line   <= ln;
    in_if.column <= col;
    in_if.value  <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_display_bytes(mode, ln, col, v);
  endtask

  // Receiver: random idling, plus the long hold counted down here.
  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_left    = LONG_HOLD;
      hold_ack_cnt = hold_req_cnt;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Checker: every output beat against the oldest expected byte.
  always @(posedge clk) begin
    lcd_beat_t exp_beat;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual byte %h is_data %b last %b",
                 $time, out_if.lcd_byte, out_if.is_data, out_if.last);
        mismatch_cnt++;
      end else begin
        exp_beat = pending_bytes.pop_front();
        if (out_if.lcd_byte !== exp_beat.lcd_byte) begin
          $display("%0t lcd_byte mismatch: expected %h actual %h",
                   $time, exp_beat.lcd_byte, out_if.lcd_byte);
          mismatch_cnt++;
        end
        if (out_if.is_data !== exp_beat.is_data) begin
          $display("%0t is_data mismatch: expected %b actual %b",
                   $time, exp_beat.is_data, out_if.is_data);
          mismatch_cnt++;
        end
        if (out_if.last !== exp_beat.last) begin
          $display("%0t last mismatch: expected %b actual %b",
                   $time, exp_beat.last, out_if.last);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles, %0d bytes outstanding",
               $time, quiet_cycles, pending_bytes.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Address command: both lines, out-of-range lines, column zero and large columns.
  task automatic test_address_set();
    logic [1:0] lns[9]  = '{2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1};
    logic [5:0] cols[9] = '{6'd1, 6'd1, 6'd40, 6'd40, 6'd0, 6'd0, 6'd17, 6'd63, 6'd63};
    foreach (lns[i]) send_number(MODE_DEC, lns[i], cols[i], 16'd5);
  endtask

  // Signed decimal: zero, digit-count edges, both extremes, negatives.
  task automatic test_decimal_values();
    logic [15:0] vals[9] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd12345, 16'h7FFF,
                             16'h8000, 16'hFFFF, 16'hFFF6};
    foreach (vals[i]) send_number(MODE_DEC, 2'(1 + i % 2), 6'(1 + 4 * i), vals[i]);
  endtask

  // Unsigned hex: zero, letter digits, top bit set, all ones.
  task automatic test_hex_values();
    logic [15:0] vals[7] = '{16'h0000, 16'h000A, 16'h000F, 16'h0010, 16'hABCD,
                             16'h8000, 16'hFFFF};
    foreach (vals[i]) send_number(MODE_HEX, 2'(2 - i % 2), 6'(40 - 5 * i), vals[i]);
  endtask

  // Random numbers; values lean toward the edges where digit counts change.
  task automatic test_random_numbers(input int n_items);
    logic        mode;
    logic [1:0]  ln;
    logic [5:0]  col;
    logic [15:0] v;
    int          sel;
    repeat (n_items) begin
      mode = 1'($urandom);
      ln   = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2)) : 2'($urandom);
      col  = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 40)) : 6'($urandom);
      sel  = $urandom_range(0, 9);
      case (sel) inside
        [0:3]:   v = 16'($urandom);
        [4:5]:   v = 16'($urandom_range(0, 20));
        6:       v = 16'h7FF0 + 16'($urandom_range(0, 31));
        7:       v = 16'hFFE0 + 16'($urandom_range(0, 31));
        default: v = 16'($urandom) & 16'((32'd1 << $urandom_range(1, 16)) - 1);
      endcase
      send_number(mode, ln, col, v);
    end
    in_if.valid <= 1'b0;
  endtask

  // Receiver stops for a long stretch while numbers keep coming back to back,
  // so the stages fill and the input must stall without losing anything.
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    hold_req_cnt++;
    test_random_numbers(40);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.cmd    = MODE_DEC;
    in_if.line   = lcdn_pkg::LINE_FIRST;
    in_if.column = 6'd1;
    in_if.value  = 16'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct  = 21;
    sink_idle_pct = 47;
    test_address_set();
    test_decimal_values();
    test_hex_values();
    in_if.valid <= 1'b0;
    test_random_numbers(90);

    src_idle_pct  = 47;
    sink_idle_pct = 21;
    test_random_numbers(90);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_numbers(90);
    test_output_backpressure();

    wait (pending_bytes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
